>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent check wrappers shared by the dot product / norm engine modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that prop holds at every clock edge outside reset.
`define DPN_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");
// Check that cons holds in the cycle after ante, outside reset.
`define DPN_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define DPN_ASSERT(label, clk, rst, prop)
`define DPN_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> src/dpn_pkg.sv
// ----------------------------------------------------------------------------
// dpn_pkg
// Shared widths, codes and types of the dot product / norm engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpn_pkg;

  localparam int ELEMENT_WIDTH = 32;
  localparam int PORT_W        = 32;
  localparam int PROD_W        = 2 * ELEMENT_WIDTH;
  localparam int ACC_W         = 64;
  localparam int ROOT_W        = ACC_W / 2;
  localparam int REM_W         = ROOT_W + 2;
  localparam int ROOT_STEPS    = ROOT_W;
  localparam int CNT_W         = $clog2(ROOT_STEPS);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};

  localparam logic OP_DOT  = 1'b0;
  localparam logic OP_NORM = 1'b1;

  // One finished vector: final sum and how to turn it into a result.
  typedef struct packed {
    logic [ACC_W-1:0] sum;
    logic             op;
    logic             sat;
  } entry_t;

  typedef enum logic [0:0] {
    BK_IDLE,
    BK_ROOT
  } back_state_t;

endpackage

>>> src/dot_product_norm_engine.sv
// ----------------------------------------------------------------------------
// dot_product_norm_engine
// Streaming Q16.16 dot product and Euclidean norm with saturating Q32.32 sum.
// ----------------------------------------------------------------------------
// The engine takes one element word per cycle while full is low: a product
// stage and a saturating 64-bit accumulator sit in the front end. The word
// marked last_element places its finished sum in a two-entry queue; a dot
// product result passes from the product stage through the queue to the
// result register, while a norm passes through an iterative square root unit
// that makes one root bit per cycle and holds its last bit until the result
// register is free. The unit spends one load step and 32 root bits per norm
// and takes no new sum until its root is done, so later finished vectors
// wait in the queue meanwhile. full rises only when both queue entries are
// taken and another vector end waits in the product stage; status reports
// saturation of the sum anywhere in that vector.
`timescale 1ns / 1ps

module dot_product_norm_engine (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic                             operation,
  input  logic signed [dpn_pkg::PORT_W-1:0] a_elem,
  input  logic signed [dpn_pkg::PORT_W-1:0] b_elem,
  input  logic                             last_element,
  input  logic                             pop,
  output logic                             empty,
  output logic signed [dpn_pkg::ACC_W-1:0] result_value,
  output logic                             status
);

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;
  dpn_pkg::entry_t q_wdata;
  dpn_pkg::entry_t q_rdata;

  dpn_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .operation    (operation),
    .a_elem       (a_elem),
    .b_elem       (b_elem),
    .last_element (last_element),
    .q_push       (q_push),
    .q_full       (q_full),
    .q_wdata      (q_wdata)
  );

  dpn_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .full  (q_full),
    .wdata (q_wdata),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  dpn_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .result_value (result_value),
    .status       (status)
  );

endmodule

>>> src/dpn_front.sv
// ----------------------------------------------------------------------------
// dpn_front
// Multiply stage and saturating Q32.32 accumulator; hands finished sums on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dpn_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic                             operation,
  input  logic signed [dpn_pkg::PORT_W-1:0] a_elem,
  input  logic signed [dpn_pkg::PORT_W-1:0] b_elem,
  input  logic                             last_element,
  output logic                             q_push,
  input  logic                             q_full,
  output dpn_pkg::entry_t                  q_wdata
);

  logic signed [dpn_pkg::ELEMENT_WIDTH-1:0] a_s;
  logic signed [dpn_pkg::ELEMENT_WIDTH-1:0] b_s;
  logic signed [dpn_pkg::ELEMENT_WIDTH-1:0] mul_b;
  logic signed [dpn_pkg::PROD_W-1:0]        prod;

  logic                              p_valid;
  logic                              p_op;
  logic                              p_last;
  logic signed [dpn_pkg::PROD_W-1:0] p_prod;

  logic [dpn_pkg::ACC_W-1:0] acc;
  logic [dpn_pkg::ACC_W-1:0] acc_next;
  logic                      sat_flag;
  logic                      sat_flag_next;

  logic [dpn_pkg::ACC_W-1:0] term;
  logic [dpn_pkg::ACC_W-1:0] sum;
  logic [dpn_pkg::ACC_W-1:0] acc_add;
  logic                      ovf;
  logic                      sat_add;
  logic                      stall;

  assign a_s   = a_elem[dpn_pkg::ELEMENT_WIDTH-1:0];
  assign b_s   = b_elem[dpn_pkg::ELEMENT_WIDTH-1:0];
  assign mul_b = (operation == dpn_pkg::OP_NORM) ? a_s : b_s;
  assign prod  = a_s * mul_b;

  // hold the product stage while a finished sum has no queue slot
  assign stall = p_valid && p_last && q_full;
  assign full  = stall;

  always_comb begin
    term    = dpn_pkg::ACC_W'(p_prod);
    sum     = acc + term;
    ovf     = (acc[dpn_pkg::ACC_W-1] ^ sum[dpn_pkg::ACC_W-1]) &
              (term[dpn_pkg::ACC_W-1] ^ sum[dpn_pkg::ACC_W-1]);
    acc_add = sum;
    if (ovf) begin
      acc_add = term[dpn_pkg::ACC_W-1] ? dpn_pkg::ACC_MIN : dpn_pkg::ACC_MAX;
    end
    sat_add = sat_flag | ovf;

    acc_next      = acc;
    sat_flag_next = sat_flag;
    if (p_valid && !stall) begin
      if (p_last) begin
        acc_next      = '0;
        sat_flag_next = 1'b0;
      end else begin
        acc_next      = acc_add;
        sat_flag_next = sat_add;
      end
    end

    q_push       = p_valid && p_last && !q_full;
    q_wdata.sum  = acc_add;
    q_wdata.op   = p_op;
    q_wdata.sat  = sat_add;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid  <= 1'b0;
      acc      <= '0;
      sat_flag <= 1'b0;
    end else begin
      acc      <= acc_next;
      sat_flag <= sat_flag_next;
      if (!stall) begin
        p_valid <= push;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      p_op   <= operation;
      p_last <= last_element;
      p_prod <= prod;
    end
  end

  `DPN_ASSERT_NEXT(a_front_clear, clk, rst, p_valid && p_last && !q_full, acc == '0 && !sat_flag)
  `DPN_ASSERT_NEXT(a_front_hold, clk, rst, stall, $stable(p_prod) && p_valid)

endmodule

>>> src/dpn_queue.sv
// ----------------------------------------------------------------------------
// dpn_queue
// Short queue of finished sums between the accumulator and the root unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dpn_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  dpn_pkg::entry_t wdata,
  input  logic            pop,
  output logic            empty,
  output dpn_pkg::entry_t rdata
);

  dpn_pkg::entry_t             mem [dpn_pkg::QDEPTH];
  logic [dpn_pkg::QPTR_W-1:0]  wr_ptr;
  logic [dpn_pkg::QPTR_W-1:0]  rd_ptr;
  logic [dpn_pkg::QCNT_W-1:0]  count;
  logic                        do_push;
  logic                        do_pop;

  assign full    = (count == dpn_pkg::QCNT_W'(dpn_pkg::QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == dpn_pkg::QPTR_W'(dpn_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == dpn_pkg::QPTR_W'(dpn_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `DPN_ASSERT(a_queue_bound, clk, rst, count <= dpn_pkg::QCNT_W'(dpn_pkg::QDEPTH))
  `DPN_ASSERT(a_queue_no_underflow, clk, rst, !(pop && empty))

endmodule

>>> src/dpn_back.sv
// ----------------------------------------------------------------------------
// dpn_back
// Forms results: passes dot sums through, runs a bit-per-cycle square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dpn_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_empty,
  input  dpn_pkg::entry_t                  q_rdata,
  output logic                             q_pop,
  input  logic                             pop,
  output logic                             empty,
  output logic signed [dpn_pkg::ACC_W-1:0] result_value,
  output logic                             status
);

  dpn_pkg::back_state_t state;
  dpn_pkg::back_state_t state_next;

  logic [dpn_pkg::ACC_W-1:0]  x;
  logic [dpn_pkg::ACC_W-1:0]  x_next;
  logic [dpn_pkg::REM_W-1:0]  rem;
  logic [dpn_pkg::REM_W-1:0]  rem_next;
  logic [dpn_pkg::ROOT_W-1:0] root;
  logic [dpn_pkg::ROOT_W-1:0] root_next;
  logic [dpn_pkg::CNT_W-1:0]  cnt;
  logic [dpn_pkg::CNT_W-1:0]  cnt_next;
  logic                       sat;
  logic                       sat_next;

  logic                       out_valid;
  logic                       out_valid_next;
  logic [dpn_pkg::ACC_W-1:0]  out_value;
  logic [dpn_pkg::ACC_W-1:0]  out_value_next;
  logic                       out_status;
  logic                       out_status_next;

  logic                       out_free;
  logic                       step_en;
  logic [dpn_pkg::REM_W+1:0]  rem_sh;
  logic [dpn_pkg::REM_W+1:0]  trial;
  logic                       ge;
  logic [dpn_pkg::ROOT_W-1:0] root_step;

  assign empty        = !out_valid;
  assign result_value = out_value;
  assign status       = out_status;
  assign out_free     = !out_valid || pop;
  assign step_en      = (state == dpn_pkg::BK_ROOT) && ((cnt != '0) || out_free);

  // one root bit per cycle: bring down two radicand bits, try 4*root+1
  assign rem_sh    = {rem, x[dpn_pkg::ACC_W-1 -: 2]};
  assign trial     = {2'b00, root, 2'b01};
  assign ge        = (rem_sh >= trial);
  assign root_step = {root[dpn_pkg::ROOT_W-2:0], ge};

  always_comb begin
    state_next      = state;
    x_next          = x;
    rem_next        = rem;
    root_next       = root;
    cnt_next        = cnt;
    sat_next        = sat;
    q_pop           = 1'b0;
    out_valid_next  = out_valid && !pop;
    out_value_next  = out_value;
    out_status_next = out_status;

    unique case (state)
      dpn_pkg::BK_IDLE: begin
        if (!q_empty) begin
          if (q_rdata.op == dpn_pkg::OP_DOT) begin
            if (out_free) begin
              q_pop           = 1'b1;
              out_valid_next  = 1'b1;
              out_value_next  = q_rdata.sum;
              out_status_next = q_rdata.sat;
            end
          end else begin
            q_pop      = 1'b1;
            // negative sums only come from mixed vectors: take the root of zero
            x_next     = q_rdata.sum[dpn_pkg::ACC_W-1] ? '0 : q_rdata.sum;
            rem_next   = '0;
            root_next  = '0;
            cnt_next   = dpn_pkg::CNT_W'(dpn_pkg::ROOT_STEPS - 1);
            sat_next   = q_rdata.sat;
            state_next = dpn_pkg::BK_ROOT;
          end
        end
      end
      dpn_pkg::BK_ROOT: begin
        if (step_en) begin
          x_next    = x << 2;
          rem_next  = ge ? dpn_pkg::REM_W'(rem_sh - trial) : dpn_pkg::REM_W'(rem_sh);
          root_next = root_step;
          cnt_next  = cnt - 1'b1;
          if (cnt == '0) begin
            out_valid_next  = 1'b1;
            out_value_next  = {{(dpn_pkg::ACC_W-dpn_pkg::ROOT_W){1'b0}}, root_step};
            out_status_next = sat;
            state_next      = dpn_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_next = dpn_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dpn_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    x          <= x_next;
    rem        <= rem_next;
    root       <= root_next;
    cnt        <= cnt_next;
    sat        <= sat_next;
    out_value  <= out_value_next;
    out_status <= out_status_next;
  end

  `DPN_ASSERT_NEXT(a_back_count, clk, rst, step_en && cnt != '0, cnt == $past(cnt) - 1'b1)

endmodule
